// File: hw/rtl/rws_pkg.sv
// ----------------------------------------------------------------------------
// rws_pkg
// Shared types and constants for the roulette wheel selector.
// ----------------------------------------------------------------------------
package rws_pkg;

  localparam int unsigned MaxPopDefault = 256;

  localparam int unsigned FitW = 32;   // fitness, Q16.16
  localparam int unsigned SumW = 40;   // running total, Q24.16
  localparam int unsigned RndW = 16;   // random fraction
  localparam int unsigned SelW = 8;    // index width on the result ports

  localparam int unsigned ProdW = SumW + RndW;

  localparam logic [SumW-1:0] SumMax  = '1;
  localparam logic [RndW:0]   RndFull = (RndW+1)'((1 << RndW) - 1);

  // Walk token handed from cell to cell
  typedef struct packed {
    logic            valid;
    logic            found;
    logic [SumW-1:0] r;
  } rws_tok_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_WALK,
    ST_DONE
  } rws_state_e;

  typedef enum logic [1:0] {
    TGT_IDLE,
    TGT_MUL,
    TGT_DIV
  } rws_tgt_e;

endpackage

// File: hw/rtl/rws_cell.sv
// ----------------------------------------------------------------------------
// rws_cell
// One table entry of the wheel. Holds a fitness value and, when the walk
// token passes, either claims it or takes its fitness off the remainder.
// ----------------------------------------------------------------------------
module rws_cell import rws_pkg::*; #(
  parameter int unsigned Idx = 0,
  parameter int unsigned CntW = 9,
  parameter int unsigned IdxW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [CntW-1:0] count_i,
  input  logic            wr_en_i,
  input  logic [CntW-1:0] wr_idx_i,
  input  logic [FitW-1:0] wr_data_i,
  input  rws_tok_t        tok_i,
  input  logic [IdxW-1:0] idx_i,
  output rws_tok_t        tok_o,
  output logic [IdxW-1:0] idx_o
);

  logic [FitW-1:0] fit_q;
  rws_tok_t        tok_d;
  logic            valid_q;
  logic            found_q;
  logic [SumW-1:0] r_q;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            live;
  logic [SumW-1:0] fit_ext;

  assign live    = count_i > CntW'(Idx);
  assign fit_ext = SumW'(fit_q);

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_idx_i == CntW'(Idx))) begin
      fit_q <= wr_data_i;
    end
  end

  always_comb begin
    tok_d = tok_i;
    idx_d = idx_i;
    if (tok_i.valid && !tok_i.found && live) begin
      if (fit_ext >= tok_i.r) begin
        tok_d.found = 1'b1;
        idx_d       = IdxW'(Idx);
      end else begin
        tok_d.r = tok_i.r - fit_ext;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tok_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= tok_d.found;
    r_q     <= tok_d.r;
    idx_q   <= idx_d;
  end

  assign tok_o = {valid_q, found_q, r_q};
  assign idx_o = idx_q;

endmodule

// File: hw/rtl/rws_target.sv
// ----------------------------------------------------------------------------
// rws_target
// Computes the walk target floor(rnd * total / 65535): a bit-serial
// shift-add multiply followed by a fold-and-subtract divide by 65535.
// ----------------------------------------------------------------------------
module rws_target import rws_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [RndW-1:0] rnd_i,
  input  logic [SumW-1:0] total_i,
  output logic            done_o,
  output logic [SumW-1:0] r_o
);

  localparam int unsigned CntW = $clog2(ProdW);
  // 2^16 = 1 mod 65535: each fold moves the high part into the quotient and
  // adds it back onto the low part. Four steps bring any product below 65535.
  localparam int unsigned DivSteps = 4;

  rws_tgt_e         st_q, st_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [RndW-1:0]  rnd_q, rnd_d;
  logic [SumW-1:0]  tot_q, tot_d;
  logic [ProdW-1:0] acc_q, acc_d;
  logic [SumW-1:0]  quo_q, quo_d;

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    case (st_q)
      TGT_IDLE: begin
        if (start_i) begin
          st_d  = TGT_MUL;
          cnt_d = CntW'(RndW - 1);
        end
      end
      TGT_MUL: begin
        if (cnt_q == '0) begin
          st_d  = TGT_DIV;
          cnt_d = CntW'(DivSteps - 1);
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      TGT_DIV: begin
        if (cnt_q == '0) begin
          st_d   = TGT_IDLE;
          done_d = 1'b1;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: st_d = TGT_IDLE;
    endcase
  end

  always_comb begin
    rnd_d = rnd_q;
    tot_d = tot_q;
    acc_d = acc_q;
    quo_d = quo_q;
    case (st_q)
      TGT_IDLE: begin
        if (start_i) begin
          rnd_d = rnd_i;
          tot_d = total_i;
          acc_d = '0;
          quo_d = '0;
        end
      end
      TGT_MUL: begin
        acc_d = {acc_q[ProdW-2:0], 1'b0} + (rnd_q[RndW-1] ? ProdW'(tot_q) : '0);
        rnd_d = {rnd_q[RndW-2:0], 1'b0};
      end
      TGT_DIV: begin
        if (acc_q[ProdW-1:RndW] != '0) begin
          acc_d = ProdW'(acc_q[ProdW-1:RndW]) + ProdW'(acc_q[RndW-1:0]);
          quo_d = quo_q + acc_q[ProdW-1:RndW];
        end else if (acc_q[RndW-1:0] == RndFull[RndW-1:0]) begin
          acc_d = '0;
          quo_d = quo_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= TGT_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rnd_q <= rnd_d;
    tot_q <= tot_d;
    acc_q <= acc_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign r_o    = quo_q;

endmodule

// File: hw/rtl/roulette_wheel_selector.sv
// ----------------------------------------------------------------------------
// roulette_wheel_selector
// Fitness-proportional selection over a chain of table cells.
// ----------------------------------------------------------------------------
// A load transfer appends one Q16.16 fitness to the table; it also updates
// the running total (saturating at 40 bits) and the first largest entry. A
// select transfer computes floor(rnd * total / 65535) with a bit-serial
// multiply and a short fold-and-subtract divide, then sends that target as a
// token down a chain of MaxPopulation cells, one cell per cycle, each
// subtracting its fitness until one covers the remainder. The chain length
// sets most of the time a select takes from transfer to result. Only one
// item is in work at a time. Every result carries the current best entry and
// total.
// ----------------------------------------------------------------------------
module roulette_wheel_selector import rws_pkg::*; #(
  parameter int unsigned MaxPopulation = MaxPopDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            action_i,
  input  logic            first_entry_i,
  input  logic [FitW-1:0] fitness_value_i,
  input  logic [RndW-1:0] random_value_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [SelW-1:0] selected_index_o,
  output logic            select_failed_o,
  output logic            load_dropped_o,
  output logic [SelW-1:0] fittest_index_o,
  output logic [FitW-1:0] fittest_value_o,
  output logic [SumW-1:0] total_fitness_o
);

  localparam int unsigned CntW = $clog2(MaxPopulation + 1);
  localparam int unsigned IdxW = $clog2(MaxPopulation);

  rws_state_e      st_q, st_d;

  logic [CntW-1:0] count_q, count_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  logic [FitW-1:0] best_val_q, best_val_d;

  logic            out_valid_q, out_valid_d;
  logic [SelW-1:0] sel_q, sel_d;
  logic            fail_q, fail_d;
  logic            drop_q, drop_d;

  logic            res_found_q;
  logic [IdxW-1:0] res_idx_q;

  logic            out_free;
  logic            in_xfer;
  logic            is_load;
  logic            tgt_start;
  logic            tgt_done;
  logic [SumW-1:0] tgt_r;
  logic            res_capture;
  logic            out_load_walk;

  logic [CntW-1:0] base_cnt;
  logic [SumW-1:0] base_sum;
  logic [IdxW-1:0] base_idx;
  logic [FitW-1:0] base_val;
  logic            full;
  logic            wr_en;
  logic [SumW:0]   sum_ext;

  rws_tok_t        tok   [0:MaxPopulation];
  logic [IdxW-1:0] tokidx[0:MaxPopulation];

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_xfer  = in_valid_i && !in_stall_o;
  assign is_load  = in_xfer && !action_i;

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (in_xfer && action_i) st_d = ST_CALC;
      ST_CALC: if (tgt_done) st_d = ST_WALK;
      ST_WALK: if (tok[MaxPopulation].valid) st_d = ST_DONE;
      ST_DONE: if (out_free) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall_o    = 1'b1;
    tgt_start     = 1'b0;
    res_capture   = 1'b0;
    out_load_walk = 1'b0;
    case (st_q)
      ST_IDLE: begin
        in_stall_o = !out_free;
        tgt_start  = in_xfer && action_i;
      end
      ST_CALC: ;
      ST_WALK: res_capture = tok[MaxPopulation].valid;
      ST_DONE: out_load_walk = out_free;
      default: ;
    endcase
  end

  // Table bookkeeping on a load
  assign base_cnt = first_entry_i ? '0 : count_q;
  assign base_sum = first_entry_i ? '0 : sum_q;
  assign base_idx = first_entry_i ? '0 : best_idx_q;
  assign base_val = first_entry_i ? '0 : best_val_q;
  assign full     = !first_entry_i && (count_q == CntW'(MaxPopulation));
  assign wr_en    = is_load && !full;
  assign sum_ext  = {1'b0, base_sum} + (SumW+1)'(fitness_value_i);

  always_comb begin
    count_d    = count_q;
    sum_d      = sum_q;
    best_idx_d = best_idx_q;
    best_val_d = best_val_q;
    if (wr_en) begin
      count_d = base_cnt + 1'b1;
      sum_d   = sum_ext[SumW] ? SumMax : sum_ext[SumW-1:0];
      if (fitness_value_i > base_val) begin
        best_idx_d = IdxW'(base_cnt);
        best_val_d = fitness_value_i;
      end else begin
        best_idx_d = base_idx;
        best_val_d = base_val;
      end
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    sel_d       = sel_q;
    fail_d      = fail_q;
    drop_d      = drop_q;
    if (is_load) begin
      out_valid_d = 1'b1;
      sel_d       = '0;
      fail_d      = 1'b0;
      drop_d      = full;
    end else if (out_load_walk) begin
      out_valid_d = 1'b1;
      sel_d       = res_found_q ? SelW'(res_idx_q) : '0;
      fail_d      = !res_found_q;
      drop_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      count_q     <= '0;
      sum_q       <= '0;
      best_idx_q  <= '0;
      best_val_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      best_idx_q  <= best_idx_d;
      best_val_q  <= best_val_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q  <= sel_d;
    fail_q <= fail_d;
    drop_q <= drop_d;
    if (res_capture) begin
      res_found_q <= tok[MaxPopulation].found;
      res_idx_q   <= tokidx[MaxPopulation];
    end
  end

  rws_target u_target (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (tgt_start),
    .rnd_i   (random_value_i),
    .total_i (sum_q),
    .done_o  (tgt_done),
    .r_o     (tgt_r)
  );

  // Token enters the chain as soon as the target is ready
  assign tok[0]    = {(st_q == ST_CALC) && tgt_done, 1'b0, tgt_r};
  assign tokidx[0] = '0;

  for (genvar i = 0; i < MaxPopulation; i++) begin : g_cell
    rws_cell #(
      .Idx  (i),
      .CntW (CntW),
      .IdxW (IdxW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .count_i   (count_q),
      .wr_en_i   (wr_en),
      .wr_idx_i  (base_cnt),
      .wr_data_i (fitness_value_i),
      .tok_i     (tok[i]),
      .idx_i     (tokidx[i]),
      .tok_o     (tok[i+1]),
      .idx_o     (tokidx[i+1])
    );
  end

  assign out_valid_o      = out_valid_q;
  assign selected_index_o = sel_q;
  assign select_failed_o  = fail_q;
  assign load_dropped_o   = drop_q;
  assign fittest_index_o  = SelW'(best_idx_q);
  assign fittest_value_o  = best_val_q;
  assign total_fitness_o  = sum_q;

endmodule
